// ===== hdl/tmst_pkg.sv =====
// ============================================================================
// tmst_pkg
// Shared types, constants and the sigmoid lookup table for the 2-2-1 trainer.
// ============================================================================
`default_nettype none

package tmst_pkg;

    // Fixed-point format and network shape
    localparam int FRAC_BITS  = 12;
    localparam int SIG_DEPTH  = 256;
    localparam int NPARAM     = 9;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
    localparam int SIG_SHIFT  = 4 + FRAC_BITS - SIG_IDX_W;
    localparam int SIG_LIM    = 8 << FRAC_BITS;
    localparam logic [15:0] LR_RESET = 16'd410;

    // Parameter slots: weights then biases
    localparam logic [3:0] P_W1 = 4'd0;
    localparam logic [3:0] P_W2 = 4'd1;
    localparam logic [3:0] P_W3 = 4'd2;
    localparam logic [3:0] P_W4 = 4'd3;
    localparam logic [3:0] P_W5 = 4'd4;
    localparam logic [3:0] P_W6 = 4'd5;
    localparam logic [3:0] P_B1 = 4'd6;
    localparam logic [3:0] P_B2 = 4'd7;
    localparam logic [3:0] P_B3 = 4'd8;

    typedef enum logic [1:0] {
        FN_INFER = 2'd0,
        FN_TRAIN = 2'd1,
        FN_LOAD  = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    // Sequencer steps; the datapath decodes the current step
    typedef enum logic [4:0] {
        ST_IDLE, ST_Z1A, ST_Z1B, ST_H1, ST_Z2A, ST_Z2B, ST_H2,
        ST_Z3A, ST_Z3B, ST_OUT, ST_DO, ST_GO, ST_DH1, ST_DH2,
        ST_T5, ST_GZ1, ST_T6, ST_GZ2, ST_GRAD, ST_UPD,
        ST_LOAD, ST_READ, ST_DONE
    } t_state;

    typedef struct packed {
        t_state     step;
        logic [3:0] k;
        logic       capture;
    } t_dp_cmd;

    typedef logic [12:0] t_sig_tab [0:SIG_DEPTH-1];

    localparam longint unsigned Q30 = 64'd1 << 30;

    // Restoring unsigned divide, used only while building the table
    function automatic longint unsigned f_udiv64(input longint unsigned n,
                                                 input longint unsigned d);
        logic [64:0]       rem;
        longint unsigned   q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid at bin midpoints, exp from a short series squared eight times
    function automatic t_sig_tab f_build_sig();
        t_sig_tab        tab;
        longint          sn;
        longint unsigned a, t, u, u2, u3, u4, e, den, nu;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            sn = 2 * longint'(i) + 1 - SIG_DEPTH;
            a  = (sn < 0) ? -sn : sn;
            t  = (a << 33) / SIG_DEPTH;
            u  = t >> 8;
            u2 = (u * u) >> 30;
            u3 = (u2 * u) >> 30;
            u4 = (u3 * u) >> 30;
            e  = Q30 - u + u2 / 2 - u3 / 6 + u4 / 24;
            for (int k = 0; k < 8; k++)
                e = (e * e) >> 30;
            den = Q30 + e;
            nu  = (sn >= 0) ? (64'd1 << (30 + FRAC_BITS)) : (e << FRAC_BITS);
            tab[i] = 13'(f_udiv64(nu + (den >> 1), den));
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TABLE = f_build_sig();

endpackage

`default_nettype wire

// ===== hdl/tmst_ctrl.sv =====
// ============================================================================
// tmst_ctrl
// Step sequencer: walks forward pass, backprop and per-parameter update.
// ============================================================================
`default_nettype none

module tmst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_func,
    output logic              o_busy,
    output logic              o_done,
    output tmst_pkg::t_dp_cmd o_cmd
);
    import tmst_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_k, n_k;
    logic       accept;
    logic       r_train;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    assign o_busy = !(r_state == ST_IDLE || r_state == ST_DONE);
    assign o_done = (r_state == ST_DONE);
    assign accept = i_start && !o_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            ST_IDLE, ST_DONE: begin
                n_state = ST_IDLE;
                if (accept) begin
                    case (t_func'(i_func))
                        FN_INFER, FN_TRAIN: n_state = ST_Z1A;
                        FN_LOAD:            n_state = ST_LOAD;
                        default:            n_state = ST_READ;
                    endcase
                end
            end
            ST_Z1A:  n_state = ST_Z1B;
            ST_Z1B:  n_state = ST_H1;
            ST_H1:   n_state = ST_Z2A;
            ST_Z2A:  n_state = ST_Z2B;
            ST_Z2B:  n_state = ST_H2;
            ST_H2:   n_state = ST_Z3A;
            ST_Z3A:  n_state = ST_Z3B;
            ST_Z3B:  n_state = ST_OUT;
            ST_OUT:  n_state = r_train ? ST_DO : ST_DONE;
            ST_DO:   n_state = ST_GO;
            ST_GO:   n_state = ST_DH1;
            ST_DH1:  n_state = ST_DH2;
            ST_DH2:  n_state = ST_T5;
            ST_T5:   n_state = ST_GZ1;
            ST_GZ1:  n_state = ST_T6;
            ST_T6:   n_state = ST_GZ2;
            ST_GZ2: begin
                n_state = ST_GRAD;
                n_k     = '0;
            end
            ST_GRAD: n_state = ST_UPD;
            ST_UPD: begin
                if (r_k == P_B3) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_GRAD;
                    n_k     = r_k + 4'd1;
                end
            end
            ST_LOAD: n_state = ST_DONE;
            ST_READ: n_state = ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Remember whether the request trains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_train <= 1'b0;
        else if (accept)
            r_train <= (t_func'(i_func) == FN_TRAIN);
    end

    assign o_cmd.step    = r_state;
    assign o_cmd.k       = r_k;
    assign o_cmd.capture = accept;

    // Checks
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held for two cycles");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy) else $error("accepted request did not start");
    a_grad_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GRAD) |=> (r_state == ST_UPD)) else $error("grad not followed by update");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_k <= P_B3)) else $error("update slot out of range");

endmodule

`default_nettype wire

// ===== hdl/tmst_dp.sv =====
// ============================================================================
// tmst_dp
// Datapath: parameter file, one shared multiplier, sigmoid lookup, updates.
// ============================================================================
`default_nettype none

module tmst_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmst_pkg::t_dp_cmd   i_cmd,
    input  logic signed [23:0]  i_first_feature,
    input  logic signed [23:0]  i_second_feature,
    input  logic [12:0]         i_target,
    input  logic [3:0]          i_param_index,
    input  logic signed [23:0]  i_param_value,
    input  logic                i_cfg_wr,
    input  logic [15:0]         i_cfg_data,
    output logic [12:0]         o_prediction,
    output logic signed [23:0]  o_param_readback
);
    import tmst_pkg::*;

    localparam logic signed [37:0] Z_LIM = 38'(SIG_LIM);
    localparam logic signed [38:0] P_MAX = 39'sd8388607;
    localparam logic signed [38:0] P_MIN = -39'sd8388608;

    logic signed [23:0] r_param [0:NPARAM-1];
    logic signed [23:0] r_x0, r_x1, r_pval, r_rb;
    logic [12:0]        r_y, r_h1, r_h2, r_o, r_pred;
    logic [3:0]         r_pidx;
    logic [15:0]        r_lr;
    logic signed [47:0] r_acc;
    logic signed [36:0] r_z;
    logic [10:0]        r_dho, r_dh1, r_dh2;
    logic signed [13:0] r_go;
    logic signed [24:0] r_t;
    logic signed [22:0] r_gz1, r_gz2;
    logic signed [33:0] r_g;

    logic [3:0]         rd_idx;
    logic signed [23:0] rd_val;
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [58:0] prod, prod_sh;
    logic signed [48:0] zsum;
    logic signed [37:0] zb, zoff;
    logic [12:0]        sig_out;
    logic signed [14:0] d_val;
    logic signed [38:0] newp, newp_sat;
    t_state             step;

    assign step = i_cmd.step;

    // Single read port on the parameter file
    always_comb begin
        case (step)
            ST_Z1A:  rd_idx = P_W1;
            ST_Z1B:  rd_idx = P_W2;
            ST_H1:   rd_idx = P_B1;
            ST_Z2A:  rd_idx = P_W3;
            ST_Z2B:  rd_idx = P_W4;
            ST_H2:   rd_idx = P_B2;
            ST_Z3A:  rd_idx = P_W5;
            ST_Z3B:  rd_idx = P_W6;
            ST_OUT:  rd_idx = P_B3;
            ST_T5:   rd_idx = P_W5;
            ST_T6:   rd_idx = P_W6;
            ST_UPD:  rd_idx = i_cmd.k;
            ST_READ: rd_idx = r_pidx;
            default: rd_idx = P_W1;
        endcase
    end
    assign rd_val = (rd_idx < 4'(NPARAM)) ? r_param[rd_idx] : '0;

    // 2*(o - y)
    assign d_val = $signed({1'b0, r_o, 1'b0}) - $signed({1'b0, r_y, 1'b0});

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step)
            ST_Z1A, ST_Z2A: begin mul_a = 34'(r_x0); mul_b = 25'(rd_val); end
            ST_Z1B, ST_Z2B: begin mul_a = 34'(r_x1); mul_b = 25'(rd_val); end
            ST_Z3A: begin mul_a = $signed({21'b0, r_h1}); mul_b = 25'(rd_val); end
            ST_Z3B: begin mul_a = $signed({21'b0, r_h2}); mul_b = 25'(rd_val); end
            ST_DO: begin
                mul_a = $signed({21'b0, r_o});
                mul_b = $signed({12'b0, 13'(ONE) - r_o});
            end
            ST_GO: begin mul_a = 34'(d_val); mul_b = $signed({14'b0, r_dho}); end
            ST_DH1: begin
                mul_a = $signed({21'b0, r_h1});
                mul_b = $signed({12'b0, 13'(ONE) - r_h1});
            end
            ST_DH2: begin
                mul_a = $signed({21'b0, r_h2});
                mul_b = $signed({12'b0, 13'(ONE) - r_h2});
            end
            ST_T5, ST_T6: begin mul_a = 34'(r_go); mul_b = 25'(rd_val); end
            ST_GZ1: begin mul_a = 34'(r_t); mul_b = $signed({14'b0, r_dh1}); end
            ST_GZ2: begin mul_a = 34'(r_t); mul_b = $signed({14'b0, r_dh2}); end
            ST_GRAD: begin
                case (i_cmd.k)
                    P_W1: begin mul_a = 34'(r_gz1); mul_b = 25'(r_x0); end
                    P_W2: begin mul_a = 34'(r_gz1); mul_b = 25'(r_x1); end
                    P_W3: begin mul_a = 34'(r_gz2); mul_b = 25'(r_x0); end
                    P_W4: begin mul_a = 34'(r_gz2); mul_b = 25'(r_x1); end
                    P_W5: begin mul_a = 34'(r_go); mul_b = $signed({12'b0, r_h1}); end
                    P_W6: begin mul_a = 34'(r_go); mul_b = $signed({12'b0, r_h2}); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_UPD: begin mul_a = r_g; mul_b = $signed({9'b0, r_lr}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_sh = prod >>> FRAC_BITS;
    assign zsum    = 49'(r_acc) + 49'(prod);

    // Bias add and sigmoid lookup
    assign zb   = 38'(r_z) + 38'(rd_val);
    assign zoff = zb + Z_LIM;
    always_comb begin
        if (zb < -Z_LIM)
            sig_out = SIG_TABLE[0];
        else if (zb >= Z_LIM)
            sig_out = SIG_TABLE[SIG_DEPTH-1];
        else
            sig_out = SIG_TABLE[zoff[SIG_SHIFT +: SIG_IDX_W]];
    end

    // Saturating parameter update
    assign newp = 39'(rd_val) - 39'($signed(prod_sh[37:0]));
    always_comb begin
        if (newp > P_MAX)
            newp_sat = P_MAX;
        else if (newp < P_MIN)
            newp_sat = P_MIN;
        else
            newp_sat = newp;
    end

    // Learning rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_lr <= LR_RESET;
        else if (i_cfg_wr)
            r_lr <= i_cfg_data;
    end

    // Parameter file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPARAM; i++)
                r_param[i] <= '0;
        end else if (step == ST_UPD && i_cmd.k < 4'(NPARAM)) begin
            r_param[i_cmd.k] <= newp_sat[23:0];
        end else if (step == ST_LOAD && r_pidx < 4'(NPARAM)) begin
            r_param[r_pidx] <= r_pval;
        end
    end

    // Request capture and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred <= '0;
            r_rb   <= '0;
        end else if (i_cmd.capture) begin
            r_pred <= '0;
            r_rb   <= '0;
        end else if (step == ST_OUT) begin
            r_pred <= sig_out;
        end else if (step == ST_READ) begin
            r_rb   <= rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x0   <= i_first_feature;
            r_x1   <= i_second_feature;
            r_y    <= i_target;
            r_pidx <= i_param_index;
            r_pval <= i_param_value;
        end
    end

    // Working registers, one destination per step
    always_ff @(posedge i_clk) begin
        case (step)
            ST_Z1A, ST_Z2A, ST_Z3A: r_acc <= prod[47:0];
            ST_Z1B, ST_Z2B, ST_Z3B: r_z   <= zsum[48:12];
            ST_H1:   r_h1  <= sig_out;
            ST_H2:   r_h2  <= sig_out;
            ST_OUT:  r_o   <= sig_out;
            ST_DO:   r_dho <= prod_sh[10:0];
            ST_GO:   r_go  <= prod_sh[13:0];
            ST_DH1:  r_dh1 <= prod_sh[10:0];
            ST_DH2:  r_dh2 <= prod_sh[10:0];
            ST_T5, ST_T6: r_t <= prod_sh[24:0];
            ST_GZ1:  r_gz1 <= prod_sh[22:0];
            ST_GZ2:  r_gz2 <= prod_sh[22:0];
            ST_GRAD: begin
                case (i_cmd.k)
                    P_B1:    r_g <= 34'(r_gz1);
                    P_B2:    r_g <= 34'(r_gz2);
                    P_B3:    r_g <= 34'(r_go);
                    default: r_g <= prod_sh[33:0];
                endcase
            end
            default: ;
        endcase
    end

    assign o_prediction     = r_pred;
    assign o_param_readback = r_rb;

endmodule

`default_nettype wire

// ===== hdl/tiny_mlp_sgd_trainer_top.sv =====
// ============================================================================
// tiny_mlp_sgd_trainer_top
// 2-2-1 sigmoid network with on-chip SGD training, Q12.12 arithmetic.
// ============================================================================
// Usage:
//   A request is taken when i_start is high and o_busy low. i_func picks
//   infer, train, load parameter or read parameter.
//   The result shows for one cycle with o_done; the receiver cannot stall.
//   o_busy is low in the o_done cycle, so the next request may be taken then.
//   Infer runs the forward steps; load and read have a step of their own.
//   Multiply steps share the one multiplier and so run in turn;
//   training adds 8 backprop steps plus two steps per parameter for its
//   nine updates.
//   Learning rate is written through i_cfg_valid / i_cfg_data (always
//   ready, not gated on busy); write it only while the block is idle.
//   Reset clears all nine parameters and sets the learning rate to 410.
// ============================================================================
`default_nettype none

module tiny_mlp_sgd_trainer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_func,
    input  logic signed [23:0] i_first_feature,
    input  logic signed [23:0] i_second_feature,
    input  logic [12:0]        i_target,
    input  logic [3:0]         i_param_index,
    input  logic signed [23:0] i_param_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_done,
    output logic [12:0]        o_prediction,
    output logic signed [23:0] o_param_readback
);
    import tmst_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    tmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Datapath
    tmst_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_first_feature  (i_first_feature),
        .i_second_feature (i_second_feature),
        .i_target         (i_target),
        .i_param_index    (i_param_index),
        .i_param_value    (i_param_value),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_prediction     (o_prediction),
        .o_param_readback (o_param_readback)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the 2-2-1 sigmoid trainer. Requests are driven
// through the start/busy handshake. A predictor of the network, its table
// and its SGD update works out each expected result, and the bench checks
// every strobed result against it. The learning rate is changed between
// phases, and the sender's idle rate varies across the phases.
// ============================================================================
`default_nettype none

import tmst_pkg::*;

typedef struct {
    logic [12:0]        prediction;
    logic signed [23:0] readback;
} t_expect;

class trainer_scoreboard;
    longint  sig_lut [SIG_DEPTH];
    longint  params  [NPARAM];
    longint  rate;
    t_expect pending_results [$];
    int      mismatches;
    int      checked;
    int      trains;

    function new();
        longint          sn;
        longint unsigned a, t, u, u2, u3, u4, e, den;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            sn = 2 * longint'(i) + 1 - SIG_DEPTH;
            a  = (sn < 0) ? -sn : sn;
            t  = (a << 33) / SIG_DEPTH;
            u  = t >> 8;
            u2 = (u * u) >> 30;
            u3 = (u2 * u) >> 30;
            u4 = (u3 * u) >> 30;
            e  = (64'd1 << 30) - u + u2 / 2 - u3 / 6 + u4 / 24;
            for (int k = 0; k < 8; k++)
                e = (e * e) >> 30;
            den = (64'd1 << 30) + e;
            if (sn >= 0)
                sig_lut[i] = longint'(((64'd1 << (30 + FRAC_BITS)) + den / 2) / den);
            else
                sig_lut[i] = longint'(((e << FRAC_BITS) + den / 2) / den);
        end
        foreach (params[i]) params[i] = 0;
        rate       = longint'(LR_RESET);
        mismatches = 0;
        checked    = 0;
        trains     = 0;
    endfunction

    function longint sigmoid(longint z);
        longint lim;
        lim = longint'(SIG_LIM);
        if (z < -lim) return sig_lut[0];
        if (z >= lim) return sig_lut[SIG_DEPTH-1];
        return sig_lut[((z + lim) * SIG_DEPTH) / (longint'(16) << FRAC_BITS)];
    endfunction

    function longint clamp24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function void write_rate(logic [15:0] v);
        rate = longint'(v);
    endfunction

    // Note an accepted request: run the network and queue its result
    function void note_request(t_func fn, logic signed [23:0] f0, logic signed [23:0] f1,
                               logic [12:0] tgt, logic [3:0] idx,
                               logic signed [23:0] val);
        longint  x0, x1, y, h1, h2, o, d, go, dh1, dh2, gz1, gz2;
        longint  grad [NPARAM];
        t_expect ex;
        x0 = f0;
        x1 = f1;
        y  = longint'(tgt);
        ex.prediction = '0;
        ex.readback   = '0;
        case (fn)
            FN_INFER, FN_TRAIN: begin
                h1 = sigmoid(((params[0] * x0 + params[1] * x1) >>> FRAC_BITS) + params[6]);
                h2 = sigmoid(((params[2] * x0 + params[3] * x1) >>> FRAC_BITS) + params[7]);
                o  = sigmoid(((params[4] * h1 + params[5] * h2) >>> FRAC_BITS) + params[8]);
                ex.prediction = 13'(o);
                if (fn == FN_TRAIN) begin
                    trains++;
                    d   = 2 * (o - y);
                    go  = (d * ((o * (ONE - o)) >>> FRAC_BITS)) >>> FRAC_BITS;
                    dh1 = (h1 * (ONE - h1)) >>> FRAC_BITS;
                    dh2 = (h2 * (ONE - h2)) >>> FRAC_BITS;
                    gz1 = (((go * params[4]) >>> FRAC_BITS) * dh1) >>> FRAC_BITS;
                    gz2 = (((go * params[5]) >>> FRAC_BITS) * dh2) >>> FRAC_BITS;
                    grad[0] = (gz1 * x0) >>> FRAC_BITS;
                    grad[1] = (gz1 * x1) >>> FRAC_BITS;
                    grad[2] = (gz2 * x0) >>> FRAC_BITS;
                    grad[3] = (gz2 * x1) >>> FRAC_BITS;
                    grad[4] = (go * h1) >>> FRAC_BITS;
                    grad[5] = (go * h2) >>> FRAC_BITS;
                    grad[6] = gz1;
                    grad[7] = gz2;
                    grad[8] = go;
                    for (int i = 0; i < NPARAM; i++)
                        params[i] = clamp24(params[i] - ((rate * grad[i]) >>> FRAC_BITS));
                end
            end
            FN_LOAD: begin
                if (idx < NPARAM) params[idx] = val;
            end
            default: begin
                if (idx < NPARAM) ex.readback = 24'(params[idx]);
            end
        endcase
        pending_results = {pending_results, ex};
    endfunction

    function void check_result(logic [12:0] pred, logic signed [23:0] rb);
        t_expect ex;
        if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: prediction %0d readback %0d", pred, rb);
            mismatches++;
            return;
        end
        ex = pending_results.pop_front();
        checked++;
        if (pred !== ex.prediction) begin
            $error("prediction: expected %0d, got %0d", ex.prediction, pred);
            mismatches++;
        end
        if (rb !== ex.readback) begin
            $error("param_readback: expected %0d, got %0d", ex.readback, rb);
            mismatches++;
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [1:0]         i_func;
    logic signed [23:0] i_first_feature;
    logic signed [23:0] i_second_feature;
    logic [12:0]        i_target;
    logic [3:0]         i_param_index;
    logic signed [23:0] i_param_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data;
    logic               o_done;
    logic [12:0]        o_prediction;
    logic signed [23:0] o_param_readback;

    trainer_scoreboard net_model;
    int                idle_pct;
    int                cycles;
    int                rate_writes;

    tiny_mlp_sgd_trainer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_func           (i_func),
        .i_first_feature  (i_first_feature),
        .i_second_feature (i_second_feature),
        .i_target         (i_target),
        .i_param_index    (i_param_index),
        .i_param_value    (i_param_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_prediction     (o_prediction),
        .o_param_readback (o_param_readback)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Observe handshakes: check results before noting new requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                net_model.check_result(o_prediction, o_param_readback);
            if (i_start && !o_busy)
                net_model.note_request(t_func'(i_func), i_first_feature, i_second_feature,
                                       i_target, i_param_index, i_param_value);
            if (i_cfg_valid && o_cfg_ready) begin
                net_model.write_rate(i_cfg_data);
                rate_writes++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly moderate Q12.12 values, sometimes anything at all
    function automatic logic signed [23:0] pick_q(int span);
        if ($urandom_range(9) == 0)
            return 24'($urandom);
        return 24'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic send(t_func fn, logic signed [23:0] f0, logic signed [23:0] f1,
                        logic [12:0] tgt, logic [3:0] idx, logic signed [23:0] val);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_func           <= fn;
        i_first_feature  <= f0;
        i_second_feature <= f1;
        i_target         <= tgt;
        i_param_index    <= idx;
        i_param_value    <= val;
        do
            @(posedge i_clk);
        while (o_busy);
    endtask

    // Rate is changed only with nothing outstanding and the block idle
    task automatic set_rate(logic [15:0] v);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (net_model.pending_results.size() != 0 || o_busy)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_all(int span);
        for (int i = 0; i < NPARAM; i++)
            send(FN_LOAD, '0, '0, '0, 4'(i), pick_q(span));
    endtask

    // A phase of training runs: fresh weights, then mostly train and infer
    task automatic run_phase(int n);
        int    roll;
        int    span;
        t_func fn;
        span = ($urandom_range(3) == 0) ? 8 * ONE : 2 * ONE;
        load_all(span);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 55)      fn = FN_TRAIN;
            else if (roll < 75) fn = FN_INFER;
            else if (roll < 90) fn = FN_READ;
            else                fn = FN_LOAD;
            send(fn, pick_q(4 * ONE), pick_q(4 * ONE),
                 ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(ONE)),
                 ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(NPARAM - 1)),
                 pick_q(span));
        end
    endtask

    initial begin
        logic [15:0] rates [5];
        int          guard;
        net_model   = new();
        cycles      = 0;
        rate_writes = 0;
        idle_pct    = 0;
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_func           = FN_INFER;
        i_first_feature  = '0;
        i_second_feature = '0;
        i_target         = '0;
        i_param_index    = '0;
        i_param_value    = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero network, extremes, bad indexes, saturation
        send(FN_INFER, 24'sh7FFFFF, 24'sh800000, 13'd0, 4'd0, '0);
        send(FN_TRAIN, 24'sh7FFFFF, 24'sh800000, 13'd4096, 4'd0, '0);
        send(FN_READ, '0, '0, '0, P_B3, '0);
        send(FN_LOAD, '0, '0, '0, P_W1, 24'sh7FFFFF);
        send(FN_LOAD, '0, '0, '0, P_W2, 24'sh800000);
        send(FN_LOAD, '0, '0, '0, P_W5, 24'sh7FFFFF);
        send(FN_LOAD, '0, '0, '0, P_W6, 24'sh800000);
        send(FN_LOAD, '0, '0, '0, P_B3, 24'sh000800);
        send(FN_LOAD, '0, '0, '0, 4'd12, 24'sh123456);
        send(FN_READ, '0, '0, '0, 4'd15, '0);
        send(FN_READ, '0, '0, '0, 4'd9, '0);
        send(FN_READ, '0, '0, '0, P_W2, '0);
        send(FN_INFER, 24'sh001000, 24'sh000800, '0, '0, '0);
        send(FN_TRAIN, 24'sh001000, 24'sh7FFFFF, 13'h1FFF, '0, '0);
        send(FN_TRAIN, 24'sh800000, 24'sh001000, 13'd0, '0, '0);
        for (int i = 0; i < NPARAM; i++)
            send(FN_READ, '0, '0, '0, 4'(i), '0);
        set_rate(16'hFFFF);
        send(FN_TRAIN, 24'sh7FFFFF, 24'sh7FFFFF, 13'd0, '0, '0);
        send(FN_TRAIN, 24'sh800000, 24'sh800000, 13'd4096, '0, '0);
        send(FN_READ, '0, '0, '0, P_W1, '0);

        // Random phases over a spread of rates and idle patterns
        rates[0] = LR_RESET;
        rates[1] = 16'd0;
        rates[2] = 16'(ONE);
        rates[3] = 16'($urandom);
        rates[4] = 16'hFFFF;
        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph < 2) ? 26 : ((ph < 4) ? 82 : 0);
            set_rate(rates[ph]);
            run_phase(70);
        end
        i_start <= 1'b0;

        guard = 0;
        while (net_model.pending_results.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (net_model.pending_results.size() != 0) begin
            $error("%0d results never arrived", net_model.pending_results.size());
            net_model.mismatches++;
        end

        $display("checked %0d results, %0d training steps, %0d rate writes",
                 net_model.checked, net_model.trains, rate_writes);
        if (net_model.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
hdl/tmst_pkg.sv
hdl/tmst_ctrl.sv
hdl/tmst_dp.sv
hdl/tiny_mlp_sgd_trainer_top.sv
tb/sv/tb.sv
